/* rtl/core/tccc_pkg.sv */
// ----------------------------------------------------------------------------
// tccc_pkg
// shared types and constants of the text console cursor controller
// ----------------------------------------------------------------------------
`default_nettype none

package tccc_pkg;

    // console control bytes
    localparam logic [7:0] CHAR_TAB = 8'd9;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_CR  = 8'd13;

    // tab stop spacing
    localparam logic [8:0] TAB_STEP = 9'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_BACKBUF = 2'd2;

    // configuration reset values
    localparam logic [8:0] COLUMNS_RESET = 9'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd30;

    // result slots per input word: draw, scroll, copy
    localparam int SLOTS     = 3;
    localparam int SLOT_DRAW = 0;
    localparam int SLOT_SCRL = 1;
    localparam int SLOT_COPY = 2;

    typedef enum logic [1:0] {
        ACT_DRAW  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_SHIFT = 2'd2,
        ACT_COPY  = 2'd3
    } t_action;

    typedef struct packed {
        logic [8:0] columns;
        logic [7:0] rows;
        logic       use_back_buffer;
    } t_cfg;

    typedef struct packed {
        logic [7:0] col;
        logic [6:0] row;
        logic [6:0] ring_start;
        logic [7:0] dirty_first;
        logic [7:0] dirty_end;
    } t_cur_state;

    typedef struct packed {
        t_action    action;
        logic [7:0] glyph_code;
        logic [7:0] cell_column;
        logic [6:0] buffer_row;
        logic [7:0] copy_first;
        logic [7:0] copy_end;
        logic [6:0] ring_first;
    } t_result;

    typedef struct packed {
        logic [SLOTS-1:0]          valid;
        t_result [SLOTS-1:0]       slot;
    } t_bundle;

endpackage

`default_nettype wire

/* rtl/core/text_console_cursor_controller_top.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_controller_top
// cursor, scroll and dirty-row tracking for a text console byte stream
// ----------------------------------------------------------------------------
// usage:
//   console bytes enter on the s_axis channel, one byte per word, with tlast
//   set on the last byte of a write. each byte yields zero to three command
//   words on m_axis, in the order draw, clear-or-shift, copy; tuser carries
//   the command kind and tlast marks the final word of a byte.
//   geometry and mode come from the plain write port (index 0 columns,
//   1 rows, 2 back-buffer enable); write it only while the block is idle.
// flow:
//   a byte passes the input register and is then decoded into the result
//   register, which offers its first word; that load waits until the result
//   register is empty or is sending its last pending word. the result
//   register sends one word per cycle while m_axis_tready is high, so bytes
//   with a single word or none stream at one per cycle while the command
//   stream does not stall.
// reset:
//   cursor, ring start and dirty range clear, registers take 80 columns,
//   30 rows and back-buffer mode; no pending words remain.
// stall:
//   while m_axis_tready is low the result register holds and the input
//   register fills, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_controller_top
    import tccc_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    // console byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,   // end_of_write
    // command stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // glyph_code, cell_column, buffer_row, copy_first, copy_end, ring_first, pad
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // action
    output logic        m_axis_tlast    // last
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eow;
    t_cur_state r_state;
    t_cur_state n_state;
    t_bundle    bundle;
    t_result    res;
    logic       load_ready;
    logic       load;

    // configuration registers, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns         <= COLUMNS_RESET;
            r_cfg.rows            <= ROWS_RESET;
            r_cfg.use_back_buffer <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS: r_cfg.columns         <= i_cfg_data;
                CFG_ROWS:    r_cfg.rows            <= i_cfg_data[7:0];
                CFG_BACKBUF: r_cfg.use_back_buffer <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input register: refills when empty or whenever its word moves on
    assign load          = r_in_valid && load_ready;
    assign s_axis_tready = !r_in_valid || load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_eow  <= s_axis_tlast;
        end
    end

    // cursor state advances as a byte is decoded into the result register
    tccc_step #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_step (
        .i_cfg          (r_cfg),
        .i_char_code    (r_in_char),
        .i_end_of_write (r_in_eow),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_bundle       (bundle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (load) begin
            r_state <= n_state;
        end
    end

    tccc_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_bundle     (bundle),
        .o_load_ready (load_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_res        (res),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tuser = res.action;
    assign m_axis_tdata = {2'b00, res.ring_first, res.copy_end, res.copy_first,
                           res.buffer_row, res.cell_column, res.glyph_code};

endmodule

`default_nettype wire

/* rtl/core/tccc_step.sv */
// ----------------------------------------------------------------------------
// tccc_step
// one console byte: next cursor state and the result words it causes
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_step
    import tccc_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 128
) (
    input  t_cfg       i_cfg,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_write,
    input  t_cur_state i_state,
    output t_cur_state o_state,
    output t_bundle    o_bundle
);

    logic [8:0] ncols;
    logic [7:0] nrows;
    logic [7:0] col_last;
    logic [6:0] row_last;
    logic [7:0] col0;
    logic [6:0] row0;
    logic [6:0] rs0;
    logic [7:0] de0;
    logic [7:0] row_inc;
    logic [7:0] rs_inc;
    logic [6:0] rs_next;
    logic [7:0] brow_sum;
    logic [6:0] brow;
    logic [8:0] col_inc;
    logic [8:0] tab9;
    logic [7:0] tab_col;
    logic       bb;
    logic       nl;
    t_cur_state n;
    t_bundle    b;

    assign bb = i_cfg.use_back_buffer;

    // geometry clamped to the supported range
    assign ncols = (i_cfg.columns == 9'd0) ? 9'd1 :
                   (i_cfg.columns > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : i_cfg.columns;
    assign nrows = (i_cfg.rows == 8'd0) ? 8'd1 :
                   (i_cfg.rows > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : i_cfg.rows;
    assign col_last = 8'(ncols - 9'd1);
    assign row_last = 7'(nrows - 8'd1);

    // state pulled back inside a shrunk geometry
    assign col0 = ({1'b0, i_state.col} >= ncols) ? col_last : i_state.col;
    assign row0 = ({1'b0, i_state.row} >= nrows) ? row_last : i_state.row;
    assign rs0  = ({1'b0, i_state.ring_start} >= nrows) ? 7'd0 : i_state.ring_start;
    assign de0  = (i_state.dirty_end > nrows) ? nrows : i_state.dirty_end;

    assign row_inc  = {1'b0, row0} + 8'd1;
    assign rs_inc   = {1'b0, rs0} + 8'd1;
    assign rs_next  = (rs_inc >= nrows) ? 7'd0 : 7'(rs_inc);
    assign brow_sum = {1'b0, row0} + {1'b0, rs0};
    assign brow     = !bb ? row0 :
                      (brow_sum >= nrows) ? 7'(brow_sum - nrows) : 7'(brow_sum);
    assign col_inc  = {1'b0, col0} + 9'd1;
    assign tab9     = {1'b0, col0[7:3], 3'b000} + TAB_STEP;
    assign tab_col  = (tab9 >= ncols) ? col_last : 8'(tab9);

    always_comb begin
        n = '{col: col0, row: row0, ring_start: rs0,
              dirty_first: i_state.dirty_first, dirty_end: de0};
        b  = '0;
        nl = 1'b0;

        case (i_char_code)
            CHAR_CR: begin
            end
            CHAR_LF: begin
                nl = 1'b1;
            end
            CHAR_TAB: begin
                n.col = tab_col;
            end
            default: begin
                b.valid[SLOT_DRAW]            = 1'b1;
                b.slot[SLOT_DRAW].action      = ACT_DRAW;
                b.slot[SLOT_DRAW].glyph_code  = i_char_code;
                b.slot[SLOT_DRAW].cell_column = col0;
                b.slot[SLOT_DRAW].buffer_row  = brow;
                // extend dirty range to the cursor row
                if (de0 <= i_state.dirty_first) begin
                    n.dirty_first = {1'b0, row0};
                    n.dirty_end   = row_inc;
                end else begin
                    if (i_state.dirty_first > {1'b0, row0}) n.dirty_first = {1'b0, row0};
                    if (de0 <= {1'b0, row0}) n.dirty_end = row_inc;
                end
                if (col_inc >= ncols) nl = 1'b1;
                else n.col = 8'(col_inc);
            end
        endcase

        if (nl) begin
            n.col = 8'd0;
            if (row_inc >= nrows) begin
                b.valid[SLOT_SCRL] = 1'b1;
                if (bb) begin
                    b.slot[SLOT_SCRL].action     = ACT_CLEAR;
                    b.slot[SLOT_SCRL].buffer_row = rs0;
                    n.ring_start  = rs_next;
                    n.dirty_first = 8'd0;
                    n.dirty_end   = nrows;
                end else begin
                    b.slot[SLOT_SCRL].action = ACT_SHIFT;
                end
            end else begin
                n.row = 7'(row_inc);
            end
        end

        if (i_end_of_write) begin
            if (bb && (n.dirty_end > n.dirty_first)) begin
                b.valid[SLOT_COPY]           = 1'b1;
                b.slot[SLOT_COPY].action     = ACT_COPY;
                b.slot[SLOT_COPY].copy_first = n.dirty_first;
                b.slot[SLOT_COPY].copy_end   = n.dirty_end;
                b.slot[SLOT_COPY].ring_first = n.ring_start;
            end
            n.dirty_first = 8'd0;
            n.dirty_end   = 8'd0;
        end
    end

    assign o_state  = n;
    assign o_bundle = b;

endmodule

`default_nettype wire

/* rtl/core/tccc_outq.sv */
// ----------------------------------------------------------------------------
// tccc_outq
// result register holding the words of one item, sent one per handshake
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_outq
    import tccc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_bundle i_bundle,
    output logic    o_load_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res,
    output logic    o_last
);

    logic [SLOTS-1:0]    r_valid;
    t_result [SLOTS-1:0] r_slot;
    logic [SLOTS-1:0]    sel_hot;
    logic [SLOTS-1:0]    others;
    logic [SLOTS-1:0]    n_valid;
    logic [1:0]          sel;
    logic                take;

    // lowest pending slot goes first
    always_comb begin
        if (r_valid[SLOT_DRAW])      sel = 2'(SLOT_DRAW);
        else if (r_valid[SLOT_SCRL]) sel = 2'(SLOT_SCRL);
        else                         sel = 2'(SLOT_COPY);
    end

    assign sel_hot      = SLOTS'(1) << sel;
    assign others       = r_valid & ~sel_hot;
    assign o_valid      = |r_valid;
    assign o_res        = r_slot[sel];
    assign o_last       = (others == '0);
    assign take         = o_valid && i_ready;
    assign n_valid      = take ? others : r_valid;
    assign o_load_ready = (n_valid == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_load) begin
            r_valid <= i_bundle.valid;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_bundle.slot;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the text console cursor controller: console bytes
// stream in with random gaps, command words are predicted per accepted byte
// and checked in order against the command stream under random back-pressure
// ----------------------------------------------------------------------------

module tb;

    import tccc_pkg::*;

    localparam int COLS_MAX      = 256;
    localparam int ROWS_MAX      = 128;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_MAX    = 10;

    // register index outside the register list, writes to it do nothing
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // one console byte as it enters the block
    typedef struct {
        logic [7:0] ch;
        logic       eow;
    } t_console_byte;

    // one command word as it leaves the block
    typedef struct {
        t_result res;
        logic    last;
    } t_cmd_word;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // configuration port
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_idx  = CFG_COLUMNS;
    logic [8:0] i_cfg_data = '0;

    // console byte stream
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // char_code
    logic        s_axis_tlast  = 1'b0;  // end_of_write

    // command stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    // glyph_code, cell_column, buffer_row, copy_first, copy_end, ring_first, pad
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;          // action
    logic        m_axis_tlast;          // last

    text_console_cursor_controller_top #(
        .MAX_COLUMNS (COLS_MAX),
        .MAX_ROWS    (ROWS_MAX)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // bytes waiting to be sent and command words still owed by the block
    t_console_byte console_bytes[$];
    t_cmd_word     cmd_expect[$];
    t_cmd_word     step_words[$];

    // shadow of the registers, written together with the block's registers
    logic [8:0] cfg_columns = COLUMNS_RESET;
    logic [7:0] cfg_rows    = ROWS_RESET;
    logic       cfg_backbuf = 1'b1;

    // shadow of the cursor state
    int cur_col  = 0;
    int cur_row  = 0;
    int ring_row = 0;
    int dirty_lo = 0;
    int dirty_hi = 0;

    // idling on both sides is switched per phase
    logic idle_on     = 1'b1;
    int   mismatches  = 0;
    int   words_seen  = 0;
    int   cycle_count = 0;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else return $urandom_range(8, 30);
    endfunction

    function automatic void add_word(input t_action act, input logic [7:0] glyph,
                                     input int col, input int brow, input int cf,
                                     input int ce, input int rf);
        t_cmd_word w;
        w.res.action      = act;
        w.res.glyph_code  = glyph;
        w.res.cell_column = col[7:0];
        w.res.buffer_row  = brow[6:0];
        w.res.copy_first  = cf[7:0];
        w.res.copy_end    = ce[7:0];
        w.res.ring_first  = rf[6:0];
        w.last            = 1'b0;
        step_words.push_back(w);
    endfunction

    // column 0 of the next line, scrolling from the bottom line
    function automatic void line_feed(input int nrows);
        cur_col = 0;
        if (cur_row + 1 >= nrows) begin
            if (cfg_backbuf) begin
                // ring mode: clear the oldest ring row, rotate, redraw everything
                add_word(ACT_CLEAR, 8'd0, 0, ring_row, 0, 0, 0);
                ring_row++;
                if (ring_row >= nrows) ring_row = 0;
                dirty_lo = 0;
                dirty_hi = nrows;
            end else begin
                add_word(ACT_SHIFT, 8'd0, 0, 0, 0, 0, 0);
            end
        end else begin
            cur_row++;
        end
    endfunction

    // works out the command words of one console byte and queues them
    function automatic void advance_cursor(input logic [7:0] ch, input logic eow);
        int ncols;
        int nrows;
        int brow;
        int tab;
        tab   = int'(TAB_STEP);
        ncols = (cfg_columns == 9'd0) ? 1 :
                ((int'(cfg_columns) > COLS_MAX) ? COLS_MAX : int'(cfg_columns));
        nrows = (cfg_rows == 8'd0) ? 1 :
                ((int'(cfg_rows) > ROWS_MAX) ? ROWS_MAX : int'(cfg_rows));
        step_words.delete();

        // state left over from a larger geometry is pulled back in range
        if (cur_col >= ncols) cur_col = ncols - 1;
        if (cur_row >= nrows) cur_row = nrows - 1;
        if (ring_row >= nrows) ring_row = 0;
        if (dirty_hi > nrows) dirty_hi = nrows;

        if (ch == CHAR_CR) begin
            // carriage return does nothing
        end else if (ch == CHAR_LF) begin
            line_feed(nrows);
        end else if (ch == CHAR_TAB) begin
            cur_col += tab - (cur_col % tab);
            if (cur_col >= ncols) cur_col = ncols - 1;
        end else begin
            brow = cur_row;
            if (cfg_backbuf) begin
                brow = cur_row + ring_row;
                if (brow >= nrows) brow -= nrows;
            end
            add_word(ACT_DRAW, ch, cur_col, brow, 0, 0, 0);
            // an empty dirty range becomes just this row
            if (dirty_hi <= dirty_lo) begin
                dirty_lo = cur_row;
                dirty_hi = cur_row + 1;
            end else begin
                if (dirty_lo > cur_row) dirty_lo = cur_row;
                if (dirty_hi <= cur_row) dirty_hi = cur_row + 1;
            end
            cur_col++;
            if (cur_col >= ncols) line_feed(nrows);
        end

        // end of write: copy only in ring mode with something dirty, always empty
        if (eow) begin
            if (cfg_backbuf && dirty_hi > dirty_lo)
                add_word(ACT_COPY, 8'd0, 0, 0, dirty_lo, dirty_hi, ring_row);
            dirty_lo = 0;
            dirty_hi = 0;
        end

        if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[k]) cmd_expect.push_back(step_words[k]);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("mismatch at word %0d: %s", words_seen, msg);
    endtask

    // byte driver: holds a word until accepted, then inserts a random gap
    int send_gap = 0;
    always @(posedge i_clk) begin : drive_bytes
        t_console_byte nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) advance_cursor(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (console_bytes.size() > 0) begin
                    nxt = console_bytes.pop_front();
                    s_axis_tdata  <= nxt.ch;
                    s_axis_tlast  <= nxt.eow;
                    s_axis_tvalid <= 1'b1;
                    send_gap = idle_on ? pick_gap() : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // command sink: random stalls of mixed length
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) stall_left = 1 + pick_gap();
        end
    end

    // command checker: every accepted word against the oldest prediction
    always @(posedge i_clk) begin : check_words
        t_cmd_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (cmd_expect.size() == 0) begin
                flag_mismatch($sformatf("unexpected word action %0d tdata %h",
                                        m_axis_tuser, m_axis_tdata));
            end else begin
                want = cmd_expect.pop_front();
                if (m_axis_tuser != want.res.action)
                    flag_mismatch($sformatf("action exp %0d got %0d",
                                            want.res.action, m_axis_tuser));
                if (m_axis_tdata[7:0] != want.res.glyph_code)
                    flag_mismatch($sformatf("glyph_code exp %0d got %0d",
                                            want.res.glyph_code, m_axis_tdata[7:0]));
                if (m_axis_tdata[15:8] != want.res.cell_column)
                    flag_mismatch($sformatf("cell_column exp %0d got %0d",
                                            want.res.cell_column, m_axis_tdata[15:8]));
                if (m_axis_tdata[22:16] != want.res.buffer_row)
                    flag_mismatch($sformatf("buffer_row exp %0d got %0d",
                                            want.res.buffer_row, m_axis_tdata[22:16]));
                if (m_axis_tdata[30:23] != want.res.copy_first)
                    flag_mismatch($sformatf("copy_first exp %0d got %0d",
                                            want.res.copy_first, m_axis_tdata[30:23]));
                if (m_axis_tdata[38:31] != want.res.copy_end)
                    flag_mismatch($sformatf("copy_end exp %0d got %0d",
                                            want.res.copy_end, m_axis_tdata[38:31]));
                if (m_axis_tdata[45:39] != want.res.ring_first)
                    flag_mismatch($sformatf("ring_first exp %0d got %0d",
                                            want.res.ring_first, m_axis_tdata[45:39]));
                if (m_axis_tlast != want.last)
                    flag_mismatch($sformatf("last exp %0d got %0d", want.last, m_axis_tlast));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_console_cursor_controller_top test failed");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] ch, input logic eow);
        t_console_byte b;
        b.ch  = ch;
        b.eow = eow;
        console_bytes.push_back(b);
    endtask

    // one console write of random length, now and then broken or with a stray end
    function automatic int queue_write();
        int len;
        int r;
        t_console_byte b;
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 14) b.ch = CHAR_LF;
            else if (r < 22) b.ch = CHAR_TAB;
            else if (r < 27) b.ch = CHAR_CR;
            else b.ch = 8'($urandom_range(0, 255));
            b.eow = (k == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
            console_bytes.push_back(b);
        end
        return len;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_COLUMNS: cfg_columns = val;
            CFG_ROWS:    cfg_rows    = val[7:0];
            CFG_BACKBUF: cfg_backbuf = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [8:0] cols, input logic [7:0] nrows,
                                input logic backbuf);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, {1'b0, nrows});
        write_reg(CFG_BACKBUF, {8'd0, backbuf});
    endtask

    // sender pauses here until every owed word is in, then lets the pipe settle
    task automatic wait_drained();
        while (console_bytes.size() != 0 || s_axis_tvalid || cmd_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int got;
        logic [8:0] col_set[7] = '{9'd8, 9'd0, 9'd511, 9'd256, 9'd1, 9'd17, 9'd257};
        logic [7:0] row_set[7] = '{8'd3, 8'd0, 8'd255, 8'd128, 8'd1, 8'd4, 8'd2};
        logic       bb_set[7]  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: ignored byte, empty copy, tab, byte extremes, newlines
        queue_byte(CHAR_CR, 1'b0);
        queue_byte(CHAR_CR, 1'b1);
        queue_byte(CHAR_TAB, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(CHAR_LF, 1'b0);
        queue_byte(CHAR_LF, 1'b1);
        queue_byte(CHAR_TAB, 1'b1);
        wait_drained();

        // tiny ring: tab clamp, wrap into scroll, copy of the whole screen
        set_geometry(9'd9, 8'd2, 1'b1);
        write_reg(CFG_SPARE, 9'h1FF);
        queue_byte(CHAR_LF, 1'b0);
        queue_byte(CHAR_LF, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(CHAR_TAB, 1'b0);
        queue_byte(CHAR_TAB, 1'b0);
        queue_byte(8'h79, 1'b0);
        queue_byte(8'h7A, 1'b1);
        wait_drained();

        // direct mode: shift-up scrolls, no copy on end of write
        write_reg(CFG_BACKBUF, 9'd0);
        queue_byte(CHAR_LF, 1'b0);
        queue_byte(CHAR_LF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b1);
        wait_drained();

        // random writes over fixed corner geometries and a few random small ones
        for (int p = 0; p < 10; p++) begin
            if (p < 7) set_geometry(col_set[p], row_set[p], bb_set[p]);
            else set_geometry(9'($urandom_range(1, 24)), 8'($urandom_range(1, 6)),
                              1'($urandom_range(0, 1)));
            idle_on = (p % 3 != 1);
            got = 0;
            while (got < 16) got += queue_write();
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("text_console_cursor_controller_top test passed");
        end else begin
            $display("text_console_cursor_controller_top test failed");
        end
        $finish;
    end

endmodule
